@@ rtl/tbsf_pkg.sv @@
// shared types and constants for the breakpoint table bracket search
package tbsf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 24;
  localparam int COUNT_W     = 7;
  localparam int ENTRY_W     = 6;
  localparam int BRK_W       = 6;
  localparam int FRAC_W      = 17;
  localparam int QUO_W       = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT     = 1'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] RGM_INSIDE = 2'd0;
  localparam logic [1:0] RGM_THRESH = 2'd1;
  localparam logic [1:0] RGM_ABOVE  = 2'd2;
  localparam logic [1:0] RGM_BELOW  = 2'd3;

  localparam logic [23:0] THRESH_RESET = 24'd589824;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic {K_WRITE = 1'b0, K_QUERY = 1'b1} kind_t;

  typedef struct packed {
    logic                op;
    logic [ENTRY_W-1:0]  entry_index;
    logic [VAL_W-1:0]    entry_value;
    logic [VAL_W-1:0]    query_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          regime;
    logic [BRK_W-1:0]    bracket_index;
    logic [FRAC_W-1:0]   fraction;
  } out_item_t;

  // classified transaction passed from front to back
  typedef struct packed {
    kind_t               kind;
    logic                wr_ok;
    logic [IDX_W-1:0]    addr;
    logic [VAL_W-1:0]    value;
  } qent_t;

  typedef struct packed {
    logic [VAL_W-1:0]    threshold;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

endpackage

@@ rtl/table_bracket_search_with_fraction.sv @@
// top level: config registers, front stage, queue and search back end
//
//  channel   signals                          handshake
//  input     start, busy, in_data             taken when start && !busy
//  result    out_valid, out_data              one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_addr, cfg_wdata      written when cfg_we is high
//
// a query outside the table is classified and reported; inside the table the search
// steps down from the start bracket by up to 62 entries, one bracket read per cycle,
// and the fraction then either saturates or is divided in the bit-serial divider
// as a 16-bit quotient; a table write is done as it is popped in the idle state
// synchronous reset clears control state only
// busy rises only when the front stage and the two-entry queue are both full
module table_bracket_search_with_fraction (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  tbsf_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  output tbsf_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [tbsf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [tbsf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  logic [tbsf_pkg::VAL_W-1:0]   thresh_r, thresh_nxt;
  logic [tbsf_pkg::COUNT_W-1:0] count_r, count_nxt;
  tbsf_pkg::cfg_t               cfg;

  logic            q_full, q_push, q_empty, q_pop;
  tbsf_pkg::qent_t q_in, q_out;

  always_comb begin
    thresh_nxt = thresh_r;
    count_nxt  = count_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        tbsf_pkg::CFG_THRESHOLD: thresh_nxt = tbsf_pkg::VAL_W'(cfg_wdata);
        tbsf_pkg::CFG_COUNT:     count_nxt  = tbsf_pkg::COUNT_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= tbsf_pkg::THRESH_RESET;
      count_r  <= tbsf_pkg::COUNT_RESET;
    end else begin
      thresh_r <= thresh_nxt;
      count_r  <= count_nxt;
    end
  end

  assign cfg.threshold = thresh_r;
  assign cfg.count     = count_r;

  tbsf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  tbsf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  tbsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ rtl/tbsf_front.sv @@
// input stage: takes transactions and classifies them into queue entries
module tbsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tbsf_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output tbsf_pkg::qent_t   q_data
);

  logic            pend_vld_r, pend_vld_nxt;
  tbsf_pkg::qent_t pend_r, pend_nxt;
  logic            accept;

  assign busy   = pend_vld_r && q_full;
  assign accept = start && !busy;
  assign q_push = pend_vld_r && !q_full;
  assign q_data = pend_r;

  always_comb begin
    pend_vld_nxt = accept || (pend_vld_r && !q_push);
    pend_nxt     = pend_r;
    if (accept) begin
      pend_nxt.kind  = (in_data.op == tbsf_pkg::OP_QUERY) ? tbsf_pkg::K_QUERY
                                                          : tbsf_pkg::K_WRITE;
      // writes past the table are dropped
      pend_nxt.wr_ok = (32'(in_data.entry_index) < tbsf_pkg::TABLE_DEPTH);
      pend_nxt.addr  = tbsf_pkg::IDX_W'(in_data.entry_index);
      pend_nxt.value = (in_data.op == tbsf_pkg::OP_QUERY) ? in_data.query_value
                                                          : in_data.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

@@ rtl/tbsf_fifo.sv @@
// short queue between the front and the back
module tbsf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbsf_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tbsf_pkg::qent_t pop_data
);

  tbsf_pkg::qent_t                  ent_r [tbsf_pkg::Q_DEPTH];
  logic [tbsf_pkg::QPTR_W-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [tbsf_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full     = (cnt_r == tbsf_pkg::QCNT_W'(tbsf_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == tbsf_pkg::QPTR_W'(tbsf_pkg::Q_DEPTH - 1)) ? '0
                                                                  : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == tbsf_pkg::QPTR_W'(tbsf_pkg::Q_DEPTH - 1)) ? '0
                                                                  : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

@@ rtl/tbsf_back.sv @@
// back end: breakpoint memory, downward bracket search and serial divider
module tbsf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbsf_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  tbsf_pkg::qent_t      q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  output tbsf_pkg::out_item_t  out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_SRCH  = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  localparam int IW = tbsf_pkg::IDX_W;
  localparam int VW = tbsf_pkg::VAL_W;
  localparam int CW = tbsf_pkg::CNT_W;
  localparam int DCNT_W = $clog2(tbsf_pkg::QUO_W);

  state_t state_r, state_nxt;

  logic [VW-1:0] mem [tbsf_pkg::TABLE_DEPTH];
  logic [VW-1:0] rd_a_r, rd_b_r;
  logic [IW-1:0] ra, rb;
  logic          wr_en;

  logic [VW-1:0]                z_r, z_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;
  logic [IW-1:0]                last_r, last_nxt;
  logic                         started_r, started_nxt;
  logic [1:0]                   regime_r, regime_nxt;
  logic [VW-1:0]                rem_r, rem_nxt;
  logic [VW-1:0]                dvs_r, dvs_nxt;
  logic [tbsf_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]            dcnt_r, dcnt_nxt;
  logic [tbsf_pkg::FRAC_W-1:0]  frac_r, frac_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tbsf_pkg::out_item_t          out_r, out_nxt;

  logic [CW-1:0] n_use;
  logic [IW-1:0] nm1, nm2, start_idx;
  logic          hit;
  logic [VW-1:0] diff_z, diff_d;
  logic [VW:0]   rem_sh;
  logic          ge;

  // entries in use, clamped to 2..depth
  always_comb begin
    if (cfg.count < tbsf_pkg::COUNT_W'(2)) begin
      n_use = CW'(2);
    end else if (32'(cfg.count) > tbsf_pkg::TABLE_DEPTH) begin
      n_use = CW'(tbsf_pkg::TABLE_DEPTH);
    end else begin
      n_use = CW'(cfg.count);
    end
  end

  assign nm1       = IW'(n_use - CW'(1));
  assign nm2       = IW'(n_use - CW'(2));
  assign start_idx = (last_r > nm2) ? nm2 : last_r;
  assign hit       = (z_r > rd_a_r) || (idx_r == '0);
  assign diff_z    = z_r - rd_a_r;
  assign diff_d    = rd_b_r - rd_a_r;
  assign rem_sh    = {rem_r, 1'b0};
  assign ge        = (rem_sh >= {1'b0, dvs_r});

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign wr_en     = q_pop && (q_data.kind == tbsf_pkg::K_WRITE) && q_data.wr_ok;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    z_nxt         = z_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    started_nxt   = started_r;
    regime_nxt    = regime_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    frac_nxt      = frac_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ra            = idx_r;
    rb            = idx_r + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop && q_data.kind == tbsf_pkg::K_QUERY) begin
          z_nxt = q_data.value;
          if (!started_r) begin
            started_nxt = 1'b1;
            last_nxt    = nm2;
          end
          ra        = nm1;
          rb        = '0;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        // rd_a holds the last entry, rd_b the first
        frac_nxt = '0;
        if (z_r > cfg.threshold) begin
          regime_nxt = tbsf_pkg::RGM_THRESH;
          state_nxt  = S_OUT;
        end else if (z_r > rd_a_r) begin
          regime_nxt = tbsf_pkg::RGM_ABOVE;
          state_nxt  = S_OUT;
        end else if (z_r <= rd_b_r) begin
          regime_nxt = tbsf_pkg::RGM_BELOW;
          state_nxt  = S_OUT;
        end else begin
          regime_nxt = tbsf_pkg::RGM_INSIDE;
          idx_nxt    = start_idx;
          ra         = start_idx;
          rb         = start_idx + 1'b1;
          state_nxt  = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit) begin
          last_nxt = idx_r;
          if ((rd_b_r <= rd_a_r) || (diff_z >= diff_d)) begin
            frac_nxt  = tbsf_pkg::FRAC_ONE;
            state_nxt = S_OUT;
          end else begin
            rem_nxt   = diff_z;
            dvs_nxt   = diff_d;
            quo_nxt   = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end else begin
          idx_nxt = idx_r - 1'b1;
          ra      = idx_r - 1'b1;
          rb      = idx_r;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt  = ge ? VW'(rem_sh - {1'b0, dvs_r}) : rem_sh[VW-1:0];
        quo_nxt  = {quo_r[tbsf_pkg::QUO_W-2:0], ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(tbsf_pkg::QUO_W - 1)) begin
          frac_nxt  = {1'b0, quo_nxt};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_nxt         = 1'b1;
        out_nxt.regime        = regime_r;
        out_nxt.bracket_index = (regime_r == tbsf_pkg::RGM_INSIDE)
                                ? tbsf_pkg::BRK_W'(idx_r) : '0;
        out_nxt.fraction      = frac_r;
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_data.addr] <= q_data.value;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    z_r      <= z_nxt;
    idx_r    <= idx_nxt;
    regime_r <= regime_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    frac_r   <= frac_nxt;
    out_r    <= out_nxt;
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.regime != tbsf_pkg::RGM_INSIDE) |->
      (out_r.bracket_index == '0 && out_r.fraction == '0))
    else $error("non-inside result carries bracket or fraction");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.fraction <= tbsf_pkg::FRAC_ONE))
    else $error("fraction above one");

  a_search_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && !hit) |=>
      (state_r == S_SRCH && idx_r == IW'($past(idx_r) - 1'b1)))
    else $error("search did not step down by one entry");

  a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.regime == tbsf_pkg::RGM_INSIDE) |->
      (tbsf_pkg::BRK_W'(last_r) == out_r.bracket_index))
    else $error("remembered bracket differs from reported bracket");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_pop)
    else $error("queue popped while a query is in progress");

endmodule

@@ tb/table_bracket_search_with_fraction_test.sv @@
// testbench for the breakpoint table bracket search: directed cases before and after random tables and queries
module table_bracket_search_with_fraction_test;
  import tbsf_pkg::*;

  localparam int SETTLE_CYCLES = 150;
  localparam int RAND_ITEMS    = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // shadow of the block state, updated as each transaction is accepted
  logic [VAL_W-1:0]   bp_table [TABLE_DEPTH];
  logic [BRK_W-1:0]   last_brk;
  logic               search_on;
  logic [VAL_W-1:0]   thresh_reg;
  logic [COUNT_W-1:0] count_reg;

  out_item_t expected_brackets [$];
  out_item_t want;
  int        mismatch_count;
  bit        gaps_on;

  table_bracket_search_with_fraction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned count_in_use();
    int unsigned n;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic void predict_bracket(in_item_t it);
    int unsigned      n;
    int unsigned      i;
    logic [VAL_W-1:0] z;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W+16:0] quo;
    out_item_t        r;
    if (it.op == OP_WRITE) begin
      bp_table[it.entry_index] = it.entry_value;
      return;
    end
    n = count_in_use();
    z = it.query_value;
    r = '0;
    if (!search_on) begin
      search_on = 1'b1;
      last_brk = BRK_W'(n - 2);
    end
    if (z > thresh_reg) begin
      r.regime = RGM_THRESH;
    end else if (z > bp_table[n - 1]) begin
      r.regime = RGM_ABOVE;
    end else if (z <= bp_table[0]) begin
      r.regime = RGM_BELOW;
    end else begin
      i = (last_brk < n - 2) ? last_brk : n - 2;
      // walk down until an entry lies below the value; entry 0 always does here
      while (i > 0 && !(z > bp_table[i])) i--;
      lo = bp_table[i];
      hi = bp_table[i + 1];
      if (hi <= lo) begin
        r.fraction = FRAC_ONE;
      end else begin
        quo = {z - lo, 16'd0} / (hi - lo);
        r.fraction = (quo > FRAC_ONE) ? FRAC_ONE : quo[FRAC_W-1:0];
      end
      r.regime = RGM_INSIDE;
      r.bracket_index = BRK_W'(i);
      last_brk = BRK_W'(i);
    end
    expected_brackets.push_back(r);
  endfunction

  function automatic void check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_brackets.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual regime %0d bracket %0d fraction %0d",
                 $time, out_data.regime, out_data.bracket_index, out_data.fraction);
        mismatch_count++;
      end else begin
        want = expected_brackets.pop_front();
        check_field("regime", want.regime, out_data.regime);
        check_field("bracket_index", want.bracket_index, out_data.bracket_index);
        check_field("fraction", want.fraction, out_data.fraction);
      end
    end
  end

  task automatic send_item(in_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_bracket(it);
  endtask

  task automatic send_entry(int unsigned idx, logic [VAL_W-1:0] v);
    in_item_t it;
    it.op          = OP_WRITE;
    it.entry_index = ENTRY_W'(idx);
    it.entry_value = v;
    it.query_value = VAL_W'($urandom);
    send_item(it);
  endtask

  task automatic send_query(logic [VAL_W-1:0] z);
    in_item_t it;
    it.op          = OP_QUERY;
    it.entry_index = ENTRY_W'($urandom);
    it.entry_value = VAL_W'($urandom);
    it.query_value = z;
    send_item(it);
  endtask

  // hold off until every result is back, then let queued table writes finish
  task automatic drain_results();
    start <= 1'b0;
    while (expected_brackets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_THRESHOLD) thresh_reg = data[VAL_W-1:0];
    else count_reg = data[COUNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_count(int unsigned c);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[COUNT_W-1:0] = COUNT_W'(c);
    write_reg(CFG_COUNT, d);
  endtask

  task automatic load_spread_table();
    for (int i = 0; i < TABLE_DEPTH; i++) send_entry(i, VAL_W'(i * 32'h41000 + 32'h100));
  endtask

  // non-decreasing table; style picks wide, dense, medium or flat-step spacing
  task automatic load_table(int unsigned n, int unsigned style);
    logic [VAL_W-1:0] vals [TABLE_DEPTH];
    int unsigned      base;
    int unsigned      step_lo;
    int unsigned      step_hi;
    bit               down;
    base = $urandom_range(0, 16'hFFFF);
    step_lo = 1;
    case (style)
      0: step_hi = (24'hFFFFFF - base) / n;
      1: step_hi = 3;
      2: step_hi = 4096;
      default: begin
        step_lo = 0;
        step_hi = 2;
      end
    endcase
    vals[0] = VAL_W'(base);
    for (int i = 1; i < n; i++) vals[i] = vals[i - 1] + VAL_W'($urandom_range(step_lo, step_hi));
    down = 1'($urandom_range(0, 1));
    for (int k = 0; k < n; k++) begin
      if (down) send_entry(n - 1 - k, vals[n - 1 - k]);
      else send_entry(k, vals[k]);
    end
  endtask

  // mostly values near the current start bracket so the search descends slowly
  task automatic random_query();
    int unsigned      n;
    int unsigned      s;
    int unsigned      k;
    int unsigned      sel;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] z;
    n = count_in_use();
    s = (last_brk < n - 2) ? last_brk : n - 2;
    if ($urandom_range(0, 99) < 96)
      k = $urandom_range((s > 0) ? s - 1 : 0, (s + 4 < n - 2) ? s + 4 : n - 2);
    else
      k = $urandom_range(0, n - 2);
    lo = bp_table[k];
    hi = bp_table[k + 1];
    sel = $urandom_range(0, 99);
    if (sel < 70 && hi > lo) z = lo + 24'd1 + VAL_W'($urandom_range(0, hi - lo - 1));
    else if (sel < 78) z = hi;
    else if (sel < 84) z = bp_table[0];
    else if (sel < 90) z = bp_table[n - 1] + 24'd1;
    else z = VAL_W'($urandom);
    send_query(z);
  endtask

  task automatic test_first_query();
    load_spread_table();
    // first query lands above the reset threshold but still loads the start bracket
    send_query(24'hFFFFFF);
    write_reg(CFG_THRESHOLD, 24'hFFFFFF);
    send_query(bp_table[62] + 24'h10);
  endtask

  task automatic test_extremes();
    send_query('0);
    send_query(bp_table[0]);
    send_query(bp_table[63]);
    send_query(bp_table[63] + 24'd1);
    send_query(24'hFFFFFF);
    write_reg(CFG_THRESHOLD, bp_table[63] + 24'h10);
    send_query(thresh_reg);
    send_query(thresh_reg + 24'd1);
    write_reg(CFG_THRESHOLD, '0);
    send_query('0);
    send_query(24'd1);
    write_reg(CFG_THRESHOLD, 24'hFFFFFF);
  endtask

  task automatic test_stale_start();
    // start bracket left above the new count - 2
    set_count(40);
    send_query(bp_table[20] + 24'd5);
    // value far above the start bracket saturates the fraction
    set_count(64);
    send_query(bp_table[50] + 24'd1);
  endtask

  task automatic test_random_tables();
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      c;
    int unsigned      pick;
    logic [VAL_W-1:0] thr;
    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) thr = '1;
      else if (pick < 8) thr = VAL_W'($urandom);
      else if (pick == 8) thr = '0;
      else thr = {1'b1, 23'($urandom)};
      write_reg(CFG_THRESHOLD, thr);
      if (phase < 10) c = 64 - 6 * phase - $urandom_range(0, 3);
      else if ($urandom_range(0, 9) < 3)
        c = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(65, 127);
      else c = $urandom_range(2, 16);
      set_count(c);
      gaps_on = (phase != 1);
      n = count_in_use();
      load_table(n, $urandom_range(0, 3));
      sent += n;
      repeat ($urandom_range(30, 70)) begin
        if ($urandom_range(0, 99) < 8) send_entry($urandom_range(0, n - 1), VAL_W'($urandom));
        else random_query();
        sent++;
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_bad_divisor();
    int unsigned      k;
    logic [VAL_W-1:0] orig;
    write_reg(CFG_THRESHOLD, 24'hFFFFFF);
    set_count(64);
    load_spread_table();
    k = (last_brk < 61) ? last_brk : 61;
    orig = bp_table[k + 1];
    // flat pair at the start bracket
    send_entry(k + 1, bp_table[k]);
    send_query(bp_table[63]);
    // falling pair at the start bracket
    send_entry(k + 1, bp_table[k] - 24'd1);
    send_query(bp_table[63]);
    send_entry(k + 1, orig);
  endtask

  task automatic test_count_clamp();
    set_count(127);
    send_query(bp_table[63]);
    set_count(0);
    send_query(bp_table[0] + 24'h20800);
    send_query(bp_table[1] + 24'd1);
    set_count(1);
    send_query(bp_table[1]);
    set_count(65);
    send_query(bp_table[63] + 24'd1);
    send_query(bp_table[63]);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    thresh_reg     = THRESH_RESET;
    count_reg      = COUNT_RESET;
    last_brk       = '0;
    search_on      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_first_query();
    test_extremes();
    test_stale_start();
    test_random_tables();
    test_bad_divisor();
    test_count_clamp();
    drain_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
